// ----- rtl/ihc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ihc_pkg
// shared types, constants and helpers for the ipv4 header check
// ----------------------------------------------------------------------------
package ihc_pkg;

	localparam logic [3:0] IPV4_VERSION = 4'd4;
	localparam logic [3:0] MIN_IHL      = 4'd5;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [2:0] ST_UDP_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_VERSION  = 3'd1;
	localparam logic [2:0] ST_SHORT_HEADER = 3'd2;
	localparam logic [2:0] ST_TTL_ZERO     = 3'd3;
	localparam logic [2:0] ST_BAD_CHECKSUM = 3'd4;
	localparam logic [2:0] ST_ICMP         = 3'd5;
	localparam logic [2:0] ST_TCP          = 3'd6;
	localparam logic [2:0] ST_UNKNOWN      = 3'd7;

	localparam logic [15:0] SUM_GOOD = 16'hffff;

	localparam int TDATA_OUT_W = 104;

	typedef struct packed {
		logic [15:0] word;
		logic        start;
	} ihc_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  protocol;
		logic [15:0] total_length;
		logic [5:0]  header_bytes;
		logic [31:0] source_address;
		logic [31:0] destination_address;
	} ihc_result_t;

	// ones' complement add with end-around carry
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/ihc_in_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ihc_in_stage
// input register: captures one beat, releases it when the parse stage takes it
// ----------------------------------------------------------------------------
module ihc_in_stage import ihc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire ihc_beat_t in_beat,
	input  wire logic      take,
	output logic           valid_s1,
	output ihc_beat_t      beat_s1
);

	logic load;

	assign in_ready = !valid_s1 || take;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load || (valid_s1 && !take);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_s1 <= in_beat;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ihc_parse.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ihc_parse
// header state, field capture, running checksum and verdict
// ----------------------------------------------------------------------------
module ihc_parse import ihc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire ihc_beat_t beat,
	output logic           res_valid,
	output ihc_result_t    res
);

	logic [4:0]  idx_q;
	logic        active_q;
	logic [3:0]  ihl_q;
	logic [15:0] sum_q;
	logic [7:0]  ttl_q;
	logic [7:0]  proto_q;
	logic [15:0] len_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;

	logic        act;
	logic [4:0]  idx;
	logic [3:0]  ihl_n;
	logic [15:0] sum_n;
	logic [7:0]  ttl_n;
	logic [7:0]  proto_n;
	logic [15:0] len_n;
	logic [31:0] src_n;
	logic [31:0] dst_n;
	logic        early;
	logic        last;
	logic        done;
	logic [2:0]  early_st;
	logic [2:0]  final_st;

	always_comb begin
		act     = beat.start || active_q;
		// start clears everything before this word is taken in
		idx     = beat.start ? 5'd0 : idx_q;
		ihl_n   = beat.start ? 4'd0 : ihl_q;
		ttl_n   = beat.start ? 8'd0 : ttl_q;
		proto_n = beat.start ? 8'd0 : proto_q;
		len_n   = beat.start ? 16'd0 : len_q;
		src_n   = beat.start ? 32'd0 : src_q;
		dst_n   = beat.start ? 32'd0 : dst_q;
		sum_n   = ones_add(beat.start ? 16'd0 : sum_q, beat.word);

		case (idx)
			5'd0: ihl_n = beat.word[11:8];
			5'd1: len_n = beat.word;
			5'd4: begin
				ttl_n   = beat.word[15:8];
				proto_n = beat.word[7:0];
			end
			5'd6: src_n[31:16] = beat.word;
			5'd7: src_n[15:0]  = beat.word;
			5'd8: dst_n[31:16] = beat.word;
			5'd9: dst_n[15:0]  = beat.word;
			default: ;
		endcase

		early    = (idx == 5'd0) &&
		           ((beat.word[15:12] != IPV4_VERSION) || (beat.word[11:8] < MIN_IHL));
		early_st = (beat.word[15:12] != IPV4_VERSION) ? ST_BAD_VERSION : ST_SHORT_HEADER;
		last     = ({1'b0, idx} + 6'd1) >= {1'b0, ihl_n, 1'b0};
		done     = early || last;

		if (ttl_n == 8'd0) begin
			final_st = ST_TTL_ZERO;
		end else if (sum_n != SUM_GOOD) begin
			final_st = ST_BAD_CHECKSUM;
		end else if (proto_n == PROTO_UDP) begin
			final_st = ST_UDP_OK;
		end else if (proto_n == PROTO_ICMP) begin
			final_st = ST_ICMP;
		end else if (proto_n == PROTO_TCP) begin
			final_st = ST_TCP;
		end else begin
			final_st = ST_UNKNOWN;
		end

		res_valid = en && act && done;
		res.header_bytes = {ihl_n, 2'b00};
		if (early) begin
			res.status              = early_st;
			res.protocol            = 8'd0;
			res.total_length        = 16'd0;
			res.source_address      = 32'd0;
			res.destination_address = 32'd0;
		end else begin
			res.status              = final_st;
			res.protocol            = proto_n;
			res.total_length        = len_n;
			res.source_address      = src_n;
			res.destination_address = dst_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 5'd0;
			active_q <= 1'b0;
			ihl_q    <= 4'd0;
			sum_q    <= 16'd0;
			ttl_q    <= 8'd0;
			proto_q  <= 8'd0;
			len_q    <= 16'd0;
			src_q    <= 32'd0;
			dst_q    <= 32'd0;
		end else if (en && act) begin
			idx_q    <= done ? idx : idx + 5'd1;
			active_q <= !done;
			ihl_q    <= ihl_n;
			sum_q    <= sum_n;
			ttl_q    <= ttl_n;
			proto_q  <= proto_n;
			len_q    <= len_n;
			src_q    <= src_n;
			dst_q    <= dst_n;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ihc_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ihc_out_stage
// result register towards the master side
// ----------------------------------------------------------------------------
module ihc_out_stage import ihc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        res_valid,
	input  wire ihc_result_t res,
	output logic             can_load,
	output logic             out_valid,
	input  wire logic        out_ready,
	output ihc_result_t      out_res
);

	logic        valid_q;
	ihc_result_t res_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && res_valid) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ipv4_header_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_header_check
// streaming ipv4 header validation with ones' complement checksum
// ----------------------------------------------------------------------------
// header words enter one beat per cycle, big-endian 16-bit, with s_tuser set
// on the first word of each header. every beat is taken into an input
// register, then, once the result register has room, the parse stage adds
// it into the running ones' complement sum, captures the fields it carries
// and, where a verdict falls due, loads the result register, so a verdict
// passes both registers on its way out, and one beat per cycle is sustained
// as long as the master side keeps up; the limit per cycle is the single
// 16-bit end-around carry add and the field capture in the parse stage.
// a bad version or a header length under five 32-bit words gives a verdict
// on the first word; otherwise it comes on the last header word, with ttl zero
// ranked first, then a checksum that is not all ones, then the protocol.
// a start beat in the middle of a header drops the old one silently, and
// beats after the header or without a start are swallowed with no result.
// ----------------------------------------------------------------------------
module ipv4_header_check import ihc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// slave side
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [15:0]            s_tdata,   // header_word
	input  wire logic                   s_tuser,   // start_of_packet
	// master side
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// status[2:0], protocol[10:3], total_length[26:11], header_bytes[32:27],
	// source_address[64:33], destination_address[96:65], zero fill above
	output logic [TDATA_OUT_W-1:0]      m_tdata
);

	ihc_beat_t   in_beat;
	ihc_beat_t   beat_s1;
	logic        valid_s1;
	logic        can_load;
	logic        take;
	logic        res_valid;
	ihc_result_t res;
	ihc_result_t out_res;

	assign in_beat.word  = s_tdata;
	assign in_beat.start = s_tuser;

	// the parse stage consumes a beat only when the result register has room
	assign take = valid_s1 && can_load;

	ihc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_beat  (in_beat),
		.take     (take),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	ihc_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (take),
		.beat      (beat_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ihc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// pack the result, first field in the lowest bits
	assign m_tdata = {7'd0,
	                  out_res.destination_address,
	                  out_res.source_address,
	                  out_res.header_bytes,
	                  out_res.total_length,
	                  out_res.protocol,
	                  out_res.status};

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the streaming ipv4 header check
// ----------------------------------------------------------------------------
// header words are sent as beats on the slave side, start flag in s_tuser.
// every accepted beat is run through a local parser that keeps its own copy
// of the header state and running ones' complement sum, and any verdict it
// produces is queued. each beat leaving the master side is unpacked and
// compared field by field against the oldest queued verdict. both sides
// idle at random, with stretches of full rate, and one phase holds the
// master side off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ihc_pkg::*;

	localparam int RUN_LIMIT   = 400000;	// far above the slowest legal run
	localparam int SETTLE      = 8;		// cycles allowed after the last verdict
	localparam int HOLD_LENGTH = 300;	// long master-side hold-off

	logic clk = 1'b0;
	logic arst_n;

	logic                   s_tvalid;
	logic                   s_tready;
	logic [15:0]            s_tdata;	// header_word
	logic                   s_tuser;	// start_of_packet
	logic                   m_tvalid;
	logic                   m_tready;
	// status[2:0], protocol[10:3], total_length[26:11], header_bytes[32:27],
	// source_address[64:33], destination_address[96:65], zero fill above
	logic [TDATA_OUT_W-1:0] m_tdata;

	// parser state mirrored from the block
	logic [4:0]  hdr_index;
	bit          hdr_open;
	logic [3:0]  hdr_ihl;
	logic [15:0] hdr_sum;
	logic [7:0]  hdr_ttl;
	logic [7:0]  hdr_proto;
	logic [15:0] hdr_length;
	logic [31:0] hdr_source;
	logic [31:0] hdr_dest;

	ihc_result_t pending_verdicts[$];
	ihc_result_t oldest_verdict;

	int  mismatches    = 0;
	int  cycle_count   = 0;
	int  beats_taken   = 0;
	int  verdicts_seen = 0;
	int  verdict_tally[8];
	int  hold_cycles   = 0;	// request to the sink process
	bit  steady        = 1'b0;	// no idling on either side while set

	ipv4_header_check DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4ns clk = ~clk;

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// 16-bit add with end-around carry
	function automatic logic [15:0] fold16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	// advance the mirrored parser by one word, returns 1 when a verdict falls due
	function automatic bit parse_word(input logic [15:0] w, input bit sop,
			output ihc_result_t v);
		int idx;
		v = '0;
		if (sop) begin
			// a start always begins afresh, dropping any header in flight
			hdr_index  = '0;
			hdr_ihl    = '0;
			hdr_sum    = '0;
			hdr_ttl    = '0;
			hdr_proto  = '0;
			hdr_length = '0;
			hdr_source = '0;
			hdr_dest   = '0;
			hdr_open   = 1'b1;
		end
		if (!hdr_open)
			return 1'b0;
		idx = hdr_index;
		hdr_sum = fold16(hdr_sum, w);
		if (idx == 0) begin
			hdr_ihl = w[11:8];
			// early verdicts carry only the header length
			if (w[15:12] != IPV4_VERSION || w[11:8] < MIN_IHL) begin
				hdr_open = 1'b0;
				v.status = (w[15:12] != IPV4_VERSION) ? ST_BAD_VERSION : ST_SHORT_HEADER;
				v.header_bytes = {hdr_ihl, 2'b00};
				return 1'b1;
			end
		end else begin
			case (idx)
				1: hdr_length = w;
				4: {hdr_ttl, hdr_proto} = w;
				6: hdr_source[31:16] = w;
				7: hdr_source[15:0] = w;
				8: hdr_dest[31:16] = w;
				9: hdr_dest[15:0] = w;
				default: ;	// id, fragment, checksum and options only feed the sum
			endcase
		end
		if (idx + 1 >= 2 * int'(hdr_ihl)) begin
			hdr_open = 1'b0;
			if (hdr_ttl == 8'd0)
				v.status = ST_TTL_ZERO;
			else if (hdr_sum != SUM_GOOD)
				v.status = ST_BAD_CHECKSUM;
			else if (hdr_proto == PROTO_UDP)
				v.status = ST_UDP_OK;
			else if (hdr_proto == PROTO_ICMP)
				v.status = ST_ICMP;
			else if (hdr_proto == PROTO_TCP)
				v.status = ST_TCP;
			else
				v.status = ST_UNKNOWN;
			v.protocol            = hdr_proto;
			v.total_length        = hdr_length;
			v.header_bytes        = {hdr_ihl, 2'b00};
			v.source_address      = hdr_source;
			v.destination_address = hdr_dest;
			return 1'b1;
		end
		hdr_index = 5'(idx + 1);
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %0h, want %0h (cycle %0d)", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// offer one beat after a random gap and hold it until taken
	task automatic send_beat(input logic [15:0] word, input bit sop);
		ihc_result_t v;
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= sop;
		do @(posedge clk); while (s_tready !== 1'b1);
		beats_taken++;
		if (parse_word(word, sop, v))
			pending_verdicts.push_back(v);
	endtask

	// build a header with a correct checksum, optionally spoil one bit,
	// and send all of it or only the first cut words
	task automatic send_header(input logic [3:0] ihl, input logic [7:0] ttl,
			input logic [7:0] proto, input bit spoil, input int cut, output int sent);
		logic [15:0] words[$];
		logic [15:0] sum;
		logic [15:0] w;
		logic [7:0]  tos;
		int n;
		int k;
		n = 2 * int'(ihl);
		tos = 8'($urandom_range(0, 255));
		words.push_back({IPV4_VERSION, ihl, tos});
		repeat (3) begin
			w = 16'($urandom_range(0, 65535));	// total length, id, fragment
			words.push_back(w);
		end
		words.push_back({ttl, proto});
		words.push_back(16'h0000);		// checksum slot
		while (words.size() < n) begin
			w = 16'($urandom_range(0, 65535));	// addresses and options
			words.push_back(w);
		end
		sum = '0;
		for (k = 0; k < n; k++)
			sum = fold16(sum, words[k]);
		words[5] = ~sum;
		if (spoil) begin
			k = $urandom_range(0, n - 1);
			words[k] = words[k] ^ (16'h0001 << $urandom_range(0, 15));
		end
		sent = (cut > 0 && cut < n) ? cut : n;
		for (k = 0; k < sent; k++)
			send_beat(words[k], k == 0);
	endtask

	// stop offering and let every queued verdict come out
	task automatic wait_idle;
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// early verdicts, extreme words, idle words, a restart mid-header and
	// words trailing a finished header
	task automatic test_directed;
		int sent;
		send_beat(16'h1234, 1'b0);	// no start while idle: swallowed
		send_beat(16'hffff, 1'b1);	// version 15
		send_beat(16'h0000, 1'b1);	// version 0
		send_beat(16'h4400, 1'b1);	// four-word header length: too short
		send_beat(16'h4000, 1'b1);	// zero header length
		send_beat(16'h6500, 1'b1);	// version 6 with a sane length
		send_header(4'd5, 8'd64, PROTO_UDP, 1'b0, 4, sent);	// cut short
		send_header(4'd5, 8'd255, PROTO_UDP, 1'b0, 0, sent);	// start drops it
		send_beat(16'hffff, 1'b0);	// after the header: swallowed
		send_beat(16'h0000, 1'b0);
	endtask

	// master side held off while headers keep coming: udp, icmp, tcp, unknown protocol, ttl zero and spoiled in turn
	task automatic test_backpressure;
		int k;
		int sent;
		steady = 1'b1;
		hold_cycles = HOLD_LENGTH;
		for (k = 0; k < 36; k++) begin
			case (k % 6)
				0: send_header(4'd5, 8'd64, PROTO_UDP, 1'b0, 0, sent);
				1: send_header(4'd5, 8'd1, PROTO_ICMP, 1'b0, 0, sent);
				2: send_header(4'd6, 8'd128, PROTO_TCP, 1'b0, 0, sent);
				3: send_header(4'd7, 8'd255, 8'hff, 1'b0, 0, sent);
				4: send_header(4'd5, 8'd0, PROTO_UDP, 1'b0, 0, sent);
				default: send_header(4'd5, 8'd32, PROTO_UDP, 1'b1, 0, sent);
			endcase
		end
		steady = 1'b0;
	endtask

	// mostly well-formed headers with random content, the rest cut-off
	// headers, bad first words and stray words
	task automatic test_random_traffic;
		int useful;
		int r;
		int k;
		int sent;
		logic [3:0]  ihl;
		logic [7:0]  ttl;
		logic [7:0]  proto;
		logic [15:0] w;
		useful = 0;
		while (useful < 900) begin
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			k = $urandom_range(0, 19);
			if (k < 16)
				ihl = 4'(5 + $urandom_range(0, 2));
			else if (k < 19)
				ihl = 4'($urandom_range(8, 14));
			else
				ihl = 4'd15;
			ttl = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
			case ($urandom_range(0, 4))
				0, 4: proto = PROTO_UDP;
				1: proto = PROTO_ICMP;
				2: proto = PROTO_TCP;
				default: proto = 8'($urandom_range(0, 255));
			endcase
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_header(ihl, ttl, proto, $urandom_range(0, 6) == 0, 0, sent);
				useful += sent;
			end else if (r < 82) begin
				send_header(ihl, ttl, proto, 1'b0, $urandom_range(1, 2 * ihl - 1), sent);
				useful += sent;
			end else if (r < 92) begin
				w = 16'($urandom_range(0, 65535));
				if ($urandom_range(0, 1) == 1) begin
					if (w[15:12] == IPV4_VERSION)
						w[15:12] = w[15:12] ^ 4'h8;
				end else begin
					w[15:12] = IPV4_VERSION;
					w[11:8]  = 4'($urandom_range(0, 4));
				end
				send_beat(w, 1'b1);
				useful++;
			end else begin
				repeat ($urandom_range(1, 3)) begin
					w = 16'($urandom_range(0, 65535));
					send_beat(w, 1'b0);
				end
			end
		end
		steady = 1'b0;
	endtask

	// master side: random stall before each verdict, or a long hold on request
	initial begin : verdict_sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = steady ? 0 : $urandom_range(0, 3);
			repeat (stall) begin
				m_tready <= 1'b0;
				@(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1 && hold_cycles == 0);
		end
	end

	// compare each verdict beat against the oldest queued verdict
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				report_mismatch("verdict with none pending", m_tdata[31:0], 32'd0);
			end else begin
				oldest_verdict = pending_verdicts.pop_front();
				verdict_tally[oldest_verdict.status]++;
				check_field("status", 32'(m_tdata[2:0]), 32'(oldest_verdict.status));
				check_field("protocol", 32'(m_tdata[10:3]),
					32'(oldest_verdict.protocol));
				check_field("total_length", 32'(m_tdata[26:11]),
					32'(oldest_verdict.total_length));
				check_field("header_bytes", 32'(m_tdata[32:27]),
					32'(oldest_verdict.header_bytes));
				check_field("source_address", m_tdata[64:33],
					oldest_verdict.source_address);
				check_field("destination_address", m_tdata[96:65],
					oldest_verdict.destination_address);
				check_field("zero fill", 32'(m_tdata[TDATA_OUT_W-1:97]), 32'd0);
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_idle();
		test_backpressure();
		wait_idle();	// sender pauses until the block has drained
		test_random_traffic();
		wait_idle();

		$display("covered %0d beats and %0d verdicts, incl. a %0d-cycle output hold",
			beats_taken, verdicts_seen, HOLD_LENGTH);
		$display("verdicts: udp %0d badver %0d short %0d ttl0 %0d",
			verdict_tally[ST_UDP_OK], verdict_tally[ST_BAD_VERSION],
			verdict_tally[ST_SHORT_HEADER], verdict_tally[ST_TTL_ZERO]);
		$display("          csum %0d icmp %0d tcp %0d other %0d",
			verdict_tally[ST_BAD_CHECKSUM], verdict_tally[ST_ICMP],
			verdict_tally[ST_TCP], verdict_tally[ST_UNKNOWN]);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ihc_pkg.sv
rtl/ihc_in_stage.sv
rtl/ihc_parse.sv
rtl/ihc_out_stage.sv
rtl/ipv4_header_check.sv
dv/tb.sv
